/* rtl/core/cau_pkg.sv */
// Shared types, codes, constants and helper functions for the complex arithmetic unit.
`timescale 1ns / 1ps
package cau_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int OP_W          = 3;
    localparam int ST_W          = 2;
    localparam int PROD_W        = 64;
    localparam int SUM_W         = 66;
    localparam int MAG_W         = 65;
    localparam int DIV_Q_W       = 34;
    localparam int TOL_N         = 16;

    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;
    localparam logic [OP_W-1:0] OP_CMP = 3'd4;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_DIV0 = 2'd1;
    localparam logic [ST_W-1:0] ST_SAT  = 2'd2;

    localparam longint unsigned POW10 [TOL_N] = '{
        64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
        64'd10000000, 64'd100000000, 64'd1000000000, 64'd10000000000,
        64'd100000000000, 64'd1000000000000, 64'd10000000000000,
        64'd100000000000000, 64'd1000000000000000
    };

    typedef struct packed {
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
        logic              eq;
        logic [ST_W-1:0]   status;
    } t_result;

    typedef struct packed {
        logic [OP_W-1:0] op;
        t_result         early;
        logic            div0;
        logic            neg_re;
        logic            neg_im;
        logic            ovf_re;
        logic            ovf_im;
    } t_side;

    typedef struct packed {
        logic [PROD_W-1:0]  rem;
        logic [DIV_Q_W-1:0] q;
    } t_div_lane;

    // {saturated, value}: clamp a sign-magnitude value to 32-bit two's complement
    function automatic logic [DATA_W:0] sat_mag(input logic neg, input logic [MAG_W-1:0] mag);
        logic [DATA_W:0] res;
        if (!neg) begin
            if (mag > MAG_W'(64'h7FFF_FFFF)) res = {1'b1, 32'h7FFF_FFFF};
            else                             res = {1'b0, mag[DATA_W-1:0]};
        end else begin
            if (mag > MAG_W'(64'h8000_0000)) res = {1'b1, 32'h8000_0000};
            else                             res = {1'b0, (~mag[DATA_W-1:0]) + 32'd1};
        end
        return res;
    endfunction

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic t_div_lane div_step(input t_div_lane l, input logic [PROD_W-1:0] den);
        t_div_lane        n;
        logic [PROD_W:0]  t;
        logic             qb;
        t  = {l.rem, l.q[DIV_Q_W-1]};
        qb = (t >= {1'b0, den});
        n.rem = qb ? PROD_W'(t - {1'b0, den}) : t[PROD_W-1:0];
        n.q   = {l.q[DIV_Q_W-2:0], qb};
        return n;
    endfunction

endpackage

/* rtl/core/complex_arithmetic_unit_top.sv */
// Top level of the complex arithmetic unit: operand pipeline, divider and output skid.
`timescale 1ns / 1ps
// Complex ALU on signed fixed-point operands (FRAC_BITS fraction bits): add, subtract,
// multiply, divide (a*conj(b)/|b|^2, round half away from zero) and a tolerant equality
// test. Fully pipelined: one beat per cycle in and out unless the skid entry is full,
// which stalls every stage. A beat passes 3 operand stages, one divider capture stage,
// 34 quotient-bit stages and one output register; the divider chain sets the latency.
// A two-entry output (register plus skid) lets the pipeline accept while a result waits.
module complex_arithmetic_unit_top #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,  // a_re, a_im, b_re, b_im
    input  logic [2:0]    s_axis_tuser,  // opcode
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [63:0]   m_axis_tdata,  // result_re, result_im
    output logic [2:0]    m_axis_tuser   // is_equal, status
);
    import cau_pkg::*;

    localparam int DW = PROD_W + FRAC_BITS + 1;
    localparam logic [MAG_W-1:0] HALF = MAG_W'(1) << (FRAC_BITS - 1);
    localparam logic [MAG_W-1:0] QBIG = MAG_W'(64'h1_0000_0000);

    logic en;

    // tolerance thresholds round(2^F / 10^k)
    logic [FRAC_BITS:0] w_tol [TOL_N];
    for (genvar j = 0; j < TOL_N; j++) begin : g_tol
        localparam longint unsigned TOL_J =
            ((64'd1 << FRAC_BITS) + POW10[j] / 2) / POW10[j];
        assign w_tol[j] = (FRAC_BITS+1)'(TOL_J);
    end

    // ---------------- stage 1: input capture
    logic                     r1_v;
    logic [OP_W-1:0]          r1_op;
    logic signed [DATA_W-1:0] r1_ar, r1_ai, r1_br, r1_bi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op <= s_axis_tuser;
            r1_ar <= s_axis_tdata[31:0];
            r1_ai <= s_axis_tdata[63:32];
            r1_br <= s_axis_tdata[95:64];
            r1_bi <= s_axis_tdata[127:96];
        end
    end

    // ---------------- stage 2: products, add/sub, compare magnitudes
    logic                     r2_v;
    logic [OP_W-1:0]          r2_op;
    logic signed [PROD_W-1:0] r2_p_rr, r2_p_ii, r2_p_ri, r2_p_ir, r2_p_bb1, r2_p_bb2;
    t_result                  r2_early;
    logic                     r2_div0;
    logic [DATA_W-1:0]        r2_bm_re, r2_bm_im;
    logic [DATA_W:0]          r2_dm_re, r2_dm_im;

    t_result         n2_early;
    logic [DATA_W:0] n2_bm_re, n2_bm_im, n2_dm_re, n2_dm_im;

    always_comb begin
        logic signed [DATA_W:0] s_re, s_im, d_re, d_im, b_re, b_im;
        logic [DATA_W:0]        m_re, m_im;
        logic [DATA_W:0]        sr, si;
        s_re = (r1_op == OP_SUB) ? (DATA_W+1)'(r1_ar) - (DATA_W+1)'(r1_br)
                                 : (DATA_W+1)'(r1_ar) + (DATA_W+1)'(r1_br);
        s_im = (r1_op == OP_SUB) ? (DATA_W+1)'(r1_ai) - (DATA_W+1)'(r1_bi)
                                 : (DATA_W+1)'(r1_ai) + (DATA_W+1)'(r1_bi);
        m_re = s_re[DATA_W] ? -s_re : s_re;
        m_im = s_im[DATA_W] ? -s_im : s_im;
        sr   = sat_mag(s_re[DATA_W], MAG_W'(m_re));
        si   = sat_mag(s_im[DATA_W], MAG_W'(m_im));
        n2_early = '0;
        if (r1_op == OP_ADD || r1_op == OP_SUB) begin
            n2_early.re     = sr[DATA_W-1:0];
            n2_early.im     = si[DATA_W-1:0];
            n2_early.status = (sr[DATA_W] || si[DATA_W]) ? ST_SAT : ST_OK;
        end
        d_re = (DATA_W+1)'(r1_ar) - (DATA_W+1)'(r1_br);
        d_im = (DATA_W+1)'(r1_ai) - (DATA_W+1)'(r1_bi);
        b_re = (DATA_W+1)'(r1_br);
        b_im = (DATA_W+1)'(r1_bi);
        n2_dm_re = d_re[DATA_W] ? -d_re : d_re;
        n2_dm_im = d_im[DATA_W] ? -d_im : d_im;
        n2_bm_re = b_re[DATA_W] ? -b_re : b_re;
        n2_bm_im = b_im[DATA_W] ? -b_im : b_im;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_op    <= r1_op;
            r2_p_rr  <= r1_ar * r1_br;
            r2_p_ii  <= r1_ai * r1_bi;
            r2_p_ri  <= r1_ar * r1_bi;
            r2_p_ir  <= r1_ai * r1_br;
            r2_p_bb1 <= r1_br * r1_br;
            r2_p_bb2 <= r1_bi * r1_bi;
            r2_early <= n2_early;
            r2_div0  <= (r1_br == '0) && (r1_bi == '0);
            r2_bm_re <= n2_bm_re[DATA_W-1:0];
            r2_bm_im <= n2_bm_im[DATA_W-1:0];
            r2_dm_re <= n2_dm_re;
            r2_dm_im <= n2_dm_im;
        end
    end

    // ---------------- stage 3: cross sums, divisor, tolerance compare
    logic                    r3_v;
    logic [OP_W-1:0]         r3_op;
    logic signed [SUM_W-1:0] r3_mul_re, r3_mul_im, r3_num_re, r3_num_im;
    logic [PROD_W-1:0]       r3_den;
    t_result                 r3_early;
    logic                    r3_div0;

    t_result n3_early;

    always_comb begin
        logic [FRAC_BITS:0] thr_re, thr_im;
        thr_re = w_tol[2];
        thr_im = w_tol[2];
        // thresholds shrink with k, so the passing compares form a prefix
        for (int j = 1; j < 14; j++) begin
            if (r2_bm_re != '0 && {1'b0, r2_bm_re} < (DATA_W+1)'(w_tol[j]))
                thr_re = w_tol[j+2];
            if (r2_bm_im != '0 && {1'b0, r2_bm_im} < (DATA_W+1)'(w_tol[j]))
                thr_im = w_tol[j+2];
        end
        n3_early = r2_early;
        if (r2_op == OP_CMP) begin
            n3_early.eq = (r2_dm_re <= (DATA_W+1)'(thr_re))
                       && (r2_dm_im <= (DATA_W+1)'(thr_im));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_op     <= r2_op;
            r3_mul_re <= SUM_W'(r2_p_rr) - SUM_W'(r2_p_ii);
            r3_mul_im <= SUM_W'(r2_p_ri) + SUM_W'(r2_p_ir);
            r3_num_re <= SUM_W'(r2_p_rr) + SUM_W'(r2_p_ii);
            r3_num_im <= SUM_W'(r2_p_ir) - SUM_W'(r2_p_ri);
            r3_den    <= PROD_W'(r2_p_bb1) + PROD_W'(r2_p_bb2);
            r3_early  <= n3_early;
            r3_div0   <= r2_div0;
        end
    end

    // ---------------- stage 4: multiply rounding, divider setup
    t_side     n4_side;
    t_div_lane n4_re, n4_im;

    always_comb begin
        logic [SUM_W-1:0]  a_re, a_im;
        logic [MAG_W-1:0]  rm_re, rm_im;
        logic [DATA_W:0]   sr, si;
        logic [SUM_W-1:0]  nm_re, nm_im;
        logic [DW-1:0]     d_re, d_im;
        a_re  = r3_mul_re[SUM_W-1] ? -r3_mul_re : r3_mul_re;
        a_im  = r3_mul_im[SUM_W-1] ? -r3_mul_im : r3_mul_im;
        rm_re = (a_re[MAG_W-1:0] + HALF) >> FRAC_BITS;
        rm_im = (a_im[MAG_W-1:0] + HALF) >> FRAC_BITS;
        sr    = sat_mag(r3_mul_re[SUM_W-1] && rm_re != '0, rm_re);
        si    = sat_mag(r3_mul_im[SUM_W-1] && rm_im != '0, rm_im);

        nm_re = r3_num_re[SUM_W-1] ? -r3_num_re : r3_num_re;
        nm_im = r3_num_im[SUM_W-1] ? -r3_num_im : r3_num_im;
        d_re  = {nm_re[PROD_W-1:0], {(FRAC_BITS+1){1'b0}}};
        d_im  = {nm_im[PROD_W-1:0], {(FRAC_BITS+1){1'b0}}};
        n4_re.rem = PROD_W'(d_re[DW-1:DIV_Q_W]);
        n4_re.q   = d_re[DIV_Q_W-1:0];
        n4_im.rem = PROD_W'(d_im[DW-1:DIV_Q_W]);
        n4_im.q   = d_im[DIV_Q_W-1:0];

        n4_side        = '0;
        n4_side.op     = r3_op;
        n4_side.early  = r3_early;
        n4_side.div0   = r3_div0;
        n4_side.neg_re = r3_num_re[SUM_W-1];
        n4_side.neg_im = r3_num_im[SUM_W-1];
        // quotient would not fit the divider's bits: saturates anyway
        n4_side.ovf_re = (n4_re.rem >= r3_den);
        n4_side.ovf_im = (n4_im.rem >= r3_den);
        if (r3_op == OP_MUL) begin
            n4_side.early.re     = sr[DATA_W-1:0];
            n4_side.early.im     = si[DATA_W-1:0];
            n4_side.early.status = (sr[DATA_W] || si[DATA_W]) ? ST_SAT : ST_OK;
        end else if (r3_op == OP_DIV && r3_div0) begin
            n4_side.early.status = ST_DIV0;
        end
    end

    logic      dv_valid;
    t_side     dv_side;
    t_div_lane dv_re, dv_im;

    cau_divider #(
        .SB_W ($bits(t_side))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_v),
        .i_sb    (n4_side),
        .i_den   (r3_den),
        .i_re    (n4_re),
        .i_im    (n4_im),
        .o_valid (dv_valid),
        .o_sb    (dv_side),
        .o_re    (dv_re),
        .o_im    (dv_im)
    );

    // ---------------- final: quotient rounding and result select
    t_result p_res;

    always_comb begin
        logic [DIV_Q_W:0]  t_re, t_im;
        logic [MAG_W-1:0]  m_re, m_im;
        logic [DATA_W:0]   sr, si;
        t_re = {1'b0, dv_re.q} + (DIV_Q_W+1)'(1);
        t_im = {1'b0, dv_im.q} + (DIV_Q_W+1)'(1);
        m_re = MAG_W'(t_re[DIV_Q_W:1]) | (dv_side.ovf_re ? QBIG : '0);
        m_im = MAG_W'(t_im[DIV_Q_W:1]) | (dv_side.ovf_im ? QBIG : '0);
        sr   = sat_mag(dv_side.neg_re && m_re != '0, m_re);
        si   = sat_mag(dv_side.neg_im && m_im != '0, m_im);
        p_res = dv_side.early;
        if (dv_side.op == OP_DIV && !dv_side.div0) begin
            p_res.re     = sr[DATA_W-1:0];
            p_res.im     = si[DATA_W-1:0];
            p_res.eq     = 1'b0;
            p_res.status = (sr[DATA_W] || si[DATA_W]) ? ST_SAT : ST_OK;
        end
    end

    // ---------------- output register and skid
    logic    r_ov, r_skv;
    t_result r_od, r_skd;
    logic    p_fire;

    assign en     = !r_skv;
    assign p_fire = dv_valid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_skv <= 1'b0;
        end else if (!r_ov || m_axis_tready) begin
            if (r_skv) begin
                r_ov  <= 1'b1;
                r_od  <= r_skd;
                r_skv <= 1'b0;
            end else begin
                r_ov <= p_fire;
                if (p_fire) r_od <= p_res;
            end
        end else if (p_fire) begin
            r_skv <= 1'b1;
            r_skd <= p_res;
        end
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_od.im, r_od.re};
    assign m_axis_tuser  = {r_od.status, r_od.eq};

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skv |-> r_ov) else $error("skid holds a beat while output is empty");
    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skv |-> !s_axis_tready) else $error("input ready while skid is full");
    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[2:1] == ST_DIV0) |-> (m_axis_tdata == '0))
        else $error("divide by zero with nonzero result");
    a_eq_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0
            && m_axis_tuser[2:1] == ST_OK))
        else $error("equal flag with nonzero result or status");
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skv) |-> $past(r_ov && !m_axis_tready && p_fire))
        else $error("skid filled without a stalled output");
`endif

endmodule

/* rtl/core/cau_divider.sv */
// Pipelined restoring divider: two lanes sharing one divisor, one quotient bit per stage.
`timescale 1ns / 1ps
module cau_divider #(
    parameter int SB_W = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [SB_W-1:0]         i_sb,
    input  logic [63:0]             i_den,
    input  cau_pkg::t_div_lane      i_re,
    input  cau_pkg::t_div_lane      i_im,
    output logic                    o_valid,
    output logic [SB_W-1:0]         o_sb,
    output cau_pkg::t_div_lane      o_re,
    output cau_pkg::t_div_lane      o_im
);
    import cau_pkg::*;

    logic [DIV_Q_W:0]  r_v;
    logic [SB_W-1:0]   r_sb  [DIV_Q_W+1];
    logic [PROD_W-1:0] r_den [DIV_Q_W+1];
    t_div_lane         r_re  [DIV_Q_W+1];
    t_div_lane         r_im  [DIV_Q_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[DIV_Q_W-1:0], i_valid};
        end
    end

    // stage 0 captures, stages 1..DIV_Q_W each resolve one quotient bit
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sb[0]  <= i_sb;
            r_den[0] <= i_den;
            r_re[0]  <= i_re;
            r_im[0]  <= i_im;
            for (int s = 1; s <= DIV_Q_W; s++) begin
                r_sb[s]  <= r_sb[s-1];
                r_den[s] <= r_den[s-1];
                r_re[s]  <= div_step(r_re[s-1], r_den[s-1]);
                r_im[s]  <= div_step(r_im[s-1], r_den[s-1]);
            end
        end
    end

    assign o_valid = r_v[DIV_Q_W];
    assign o_sb    = r_sb[DIV_Q_W];
    assign o_re    = r_re[DIV_Q_W];
    assign o_im    = r_im[DIV_Q_W];

endmodule
